### src/rcsps_pkg.sv
// ----------------------------------------------------------------------------
// rcsps_pkg
// Shared types and constants for the RC signal presence selector.
// ----------------------------------------------------------------------------
package rcsps_pkg;

    // configuration register widths
    localparam int unsigned STEP_W    = 8;
    localparam int unsigned TIMEOUT_W = 24;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned PERIOD_W  = 24;
    localparam int unsigned HWIDTH_W  = 16;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_NEEDED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MAX     = 3'd6;

    // reset values
    localparam logic [STEP_W-1:0]    RST_TICK_STEP     = 8'd10;
    localparam logic [TIMEOUT_W-1:0] RST_LOSS_TIMEOUT  = 24'd200000;
    localparam logic [COUNT_W-1:0]   RST_PULSES_NEEDED = 4'd3;
    localparam logic [PERIOD_W-1:0]  RST_PERIOD_MIN    = 24'd10000;
    localparam logic [PERIOD_W-1:0]  RST_PERIOD_MAX    = 24'd50000;
    localparam logic [HWIDTH_W-1:0]  RST_WIDTH_MIN     = 16'd500;
    localparam logic [HWIDTH_W-1:0]  RST_WIDTH_MAX     = 16'd2500;

    // request kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0]    tick_step;
        logic [TIMEOUT_W-1:0] loss_timeout;
        logic [COUNT_W-1:0]   pulses_needed;
        logic [PERIOD_W-1:0]  period_min;
        logic [PERIOD_W-1:0]  period_max;
        logic [HWIDTH_W-1:0]  width_min;
        logic [HWIDTH_W-1:0]  width_max;
    } cfg_t;

    typedef struct packed {
        logic manual_mode;
        logic pulse_good;
        logic signal_lost;
    } result_t;

endpackage

### src/rcsps_cfg.sv
// ----------------------------------------------------------------------------
// rcsps_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rcsps_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rcsps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcsps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rcsps_pkg::cfg_t                   cfg
);
    import rcsps_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_step     <= RST_TICK_STEP;
            cfg_reg.loss_timeout  <= RST_LOSS_TIMEOUT;
            cfg_reg.pulses_needed <= RST_PULSES_NEEDED;
            cfg_reg.period_min    <= RST_PERIOD_MIN;
            cfg_reg.period_max    <= RST_PERIOD_MAX;
            cfg_reg.width_min     <= RST_WIDTH_MIN;
            cfg_reg.width_max     <= RST_WIDTH_MAX;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TICK_STEP:     cfg_reg.tick_step     <= cfg_data[STEP_W-1:0];
                REG_LOSS_TIMEOUT:  cfg_reg.loss_timeout  <= cfg_data[TIMEOUT_W-1:0];
                REG_PULSES_NEEDED: cfg_reg.pulses_needed <= cfg_data[COUNT_W-1:0];
                REG_PERIOD_MIN:    cfg_reg.period_min    <= cfg_data[PERIOD_W-1:0];
                REG_PERIOD_MAX:    cfg_reg.period_max    <= cfg_data[PERIOD_W-1:0];
                REG_WIDTH_MIN:     cfg_reg.width_min     <= cfg_data[HWIDTH_W-1:0];
                REG_WIDTH_MAX:     cfg_reg.width_max     <= cfg_data[HWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/rcsps_qual.sv
// ----------------------------------------------------------------------------
// rcsps_qual
// Pulse qualifier: time counters, good-pulse count and mode flag.
// ----------------------------------------------------------------------------
module rcsps_qual #(
    parameter int unsigned TIME_WIDTH = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,        // request leaves the input stage
    input  logic              operation,
    input  logic              rx_level,
    input  rcsps_pkg::cfg_t   cfg,
    output rcsps_pkg::result_t result
);
    import rcsps_pkg::*;

    localparam int unsigned CW = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;
    localparam int unsigned PW = (TIME_WIDTH + 1 > PERIOD_W) ? TIME_WIDTH + 1 : PERIOD_W;

    logic [TIME_WIDTH-1:0] high_time_reg, high_time_next;
    logic [TIME_WIDTH-1:0] low_time_reg,  low_time_next;
    logic [COUNT_W-1:0]    good_pulses_reg, good_pulses_next;
    logic                  manual_flag_reg, manual_flag_next;

    logic [TIME_WIDTH:0]   high_sum, low_sum;
    logic [TIME_WIDTH-1:0] high_sat, low_sat;
    logic [PW-1:0]         period;
    logic                  in_window;
    logic                  lost;
    logic [COUNT_W-1:0]    gp_inc;
    logic [COUNT_W:0]      limit;

    always_comb
    begin
        high_sum = {1'b0, high_time_reg} + (TIME_WIDTH+1)'(cfg.tick_step);
        low_sum  = {1'b0, low_time_reg}  + (TIME_WIDTH+1)'(cfg.tick_step);
        high_sat = high_sum[TIME_WIDTH] ? '1 : high_sum[TIME_WIDTH-1:0];
        low_sat  = low_sum[TIME_WIDTH]  ? '1 : low_sum[TIME_WIDTH-1:0];

        period = PW'(high_time_reg) + PW'(low_time_reg);
        in_window = (period > PW'(cfg.period_min)) && (period < PW'(cfg.period_max))
                 && (high_time_reg > TIME_WIDTH'(cfg.width_min))
                 && (high_time_reg < TIME_WIDTH'(cfg.width_max));

        lost   = (CW'(low_sat) > CW'(cfg.loss_timeout));
        gp_inc = (good_pulses_reg == '1) ? good_pulses_reg : good_pulses_reg + 1'b1;
        limit  = {1'b0, cfg.pulses_needed} + 1'b1;

        high_time_next   = high_time_reg;
        low_time_next    = low_time_reg;
        good_pulses_next = good_pulses_reg;
        manual_flag_next = manual_flag_reg;
        result.pulse_good  = 1'b0;
        result.signal_lost = 1'b0;

        if (operation == OP_TICK)
        begin
            if (!rx_level)
            begin
                low_time_next = low_sat;
                if (lost)
                begin
                    good_pulses_next   = '0;
                    manual_flag_next   = 1'b0;
                    result.signal_lost = 1'b1;
                end
            end
            else
            begin
                high_time_next = high_sat;
            end
        end
        else if (rx_level)
        begin
            if (in_window)
            begin
                result.pulse_good = 1'b1;
                good_pulses_next  = gp_inc;
                if (gp_inc > cfg.pulses_needed)
                begin
                    // clamp to needed + 1, at most all ones
                    good_pulses_next = limit[COUNT_W] ? '1 : limit[COUNT_W-1:0];
                    manual_flag_next = 1'b1;
                end
            end
            high_time_next = '0;
            low_time_next  = '0;
        end

        result.manual_mode = manual_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_time_reg   <= '0;
            low_time_reg    <= '0;
            good_pulses_reg <= '0;
            manual_flag_reg <= 1'b0;
        end
        else if (fire)
        begin
            high_time_reg   <= high_time_next;
            low_time_reg    <= low_time_next;
            good_pulses_reg <= good_pulses_next;
            manual_flag_reg <= manual_flag_next;
        end
    end

endmodule

### src/rc_signal_presence_selector_core.sv
// ----------------------------------------------------------------------------
// rc_signal_presence_selector_core
// RC pulse qualifier with manual / autonomous mode select.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall): one request per timer tick or pin
//   change, with operation (0 tick, 1 pin change) and the current rx_level.
//   Result channel (out_valid / out_stall): exactly one result per request,
//   manual_mode, pulse_good, signal_lost, in request order.
//   Config: cfg_data goes to register cfg_index at an edge with cfg_write high.
//   Index 7 is ignored. Write only while no request is in flight; unchecked.
// Timing:
//   Input register, qualifier logic, result register. A request is processed
//   as it moves from the input register into the result register; its result
//   stays there until taken. One request per clock while out_stall does not
//   hold a result; the single qualifier pass between the registers sets that.
// Stall:
//   in_stall rises only when the input register is full and the result
//   register is held by out_stall; both stages keep their contents.
// Reset:
//   rst_n clears the valids, counters and mode (autonomous) and loads the
//   default configuration.
// ----------------------------------------------------------------------------
module rc_signal_presence_selector_core #(
    parameter int unsigned TIME_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic                              rx_level,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              manual_mode,
    output logic                              pulse_good,
    output logic                              signal_lost,
    // config write port
    input  logic                              cfg_write,
    input  logic [rcsps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcsps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcsps_pkg::*;

    cfg_t    cfg;
    result_t result;

    // input stage
    logic    in_valid_reg;
    logic    operation_reg;
    logic    rx_level_reg;

    // result stage
    logic    out_valid_reg;
    result_t result_reg;

    logic    advance;   // result register can take a new value
    logic    fire;      // input stage request moves to the result stage
    logic    in_take;   // request accepted on the input channel

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    rcsps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcsps_qual #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_qual (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .operation (operation_reg),
        .rx_level  (rx_level_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            operation_reg <= operation;
            rx_level_reg  <= rx_level;
        end
        if (fire)
            result_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign manual_mode = result_reg.manual_mode;
    assign pulse_good  = result_reg.pulse_good;
    assign signal_lost = result_reg.signal_lost;

endmodule

### tb/rcsps_tb_pkg.sv
// ----------------------------------------------------------------------------
// rcsps_tb_pkg
// Mode prediction and result checking for the RC signal presence selector.
// ----------------------------------------------------------------------------
package rcsps_tb_pkg;

    import rcsps_pkg::*;

    localparam int unsigned TB_TIME_W = 24;
    // index beyond the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned MAX_NOTES = 100;

    class rc_mode_scoreboard;

        cfg_t                 cfg;
        logic [TB_TIME_W-1:0] high_us;
        logic [TB_TIME_W-1:0] low_us;
        logic [COUNT_W-1:0]   good_count;
        logic                 manual;
        result_t              expected_q[$];
        int unsigned          results_seen;
        int unsigned          errors;

        function new();
            cfg.tick_step     = RST_TICK_STEP;
            cfg.loss_timeout  = RST_LOSS_TIMEOUT;
            cfg.pulses_needed = RST_PULSES_NEEDED;
            cfg.period_min    = RST_PERIOD_MIN;
            cfg.period_max    = RST_PERIOD_MAX;
            cfg.width_min     = RST_WIDTH_MIN;
            cfg.width_max     = RST_WIDTH_MAX;
            high_us      = '0;
            low_us       = '0;
            good_count   = '0;
            manual       = 1'b0;
            results_seen = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TICK_STEP:     cfg.tick_step     = data[STEP_W-1:0];
                REG_LOSS_TIMEOUT:  cfg.loss_timeout  = data[TIMEOUT_W-1:0];
                REG_PULSES_NEEDED: cfg.pulses_needed = data[COUNT_W-1:0];
                REG_PERIOD_MIN:    cfg.period_min    = data[PERIOD_W-1:0];
                REG_PERIOD_MAX:    cfg.period_max    = data[PERIOD_W-1:0];
                REG_WIDTH_MIN:     cfg.width_min     = data[HWIDTH_W-1:0];
                REG_WIDTH_MAX:     cfg.width_max     = data[HWIDTH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TB_TIME_W-1:0] sat_add(logic [TB_TIME_W-1:0] acc,
                                               logic [STEP_W-1:0] inc);
            logic [TB_TIME_W:0] sum;
            sum = {1'b0, acc} + (TB_TIME_W+1)'(inc);
            return sum[TB_TIME_W] ? '1 : sum[TB_TIME_W-1:0];
        endfunction

        // advance the mode state by one accepted request, queue its result
        function void note_request(logic op, logic level);
            logic [TB_TIME_W:0] period;
            logic [COUNT_W:0]   cap;
            result_t            r;
            r = '0;
            if (op == OP_TICK) begin
                if (level == 1'b0) begin
                    low_us = sat_add(low_us, cfg.tick_step);
                    if (low_us > TB_TIME_W'(cfg.loss_timeout)) begin
                        good_count    = '0;
                        manual        = 1'b0;
                        r.signal_lost = 1'b1;
                    end
                end
                else begin
                    high_us = sat_add(high_us, cfg.tick_step);
                end
            end
            else if (level == 1'b1) begin
                period = {1'b0, high_us} + {1'b0, low_us};
                if (period > (TB_TIME_W+1)'(cfg.period_min) &&
                    period < (TB_TIME_W+1)'(cfg.period_max) &&
                    high_us > TB_TIME_W'(cfg.width_min) &&
                    high_us < TB_TIME_W'(cfg.width_max)) begin
                    cap = {1'b0, cfg.pulses_needed} + 5'd1;
                    if (cap > 5'd15)
                        cap = 5'd15;
                    r.pulse_good = 1'b1;
                    if (good_count != '1)
                        good_count = good_count + 1'b1;
                    if (good_count > cfg.pulses_needed) begin
                        good_count = cap[COUNT_W-1:0];
                        manual     = 1'b1;
                    end
                end
                high_us = '0;
                low_us  = '0;
            end
            r.manual_mode = manual;
            expected_q.push_back(r);
        endfunction

        task report(string what);
            if (errors < MAX_NOTES)
                $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
            errors++;
        endtask

        task check_result(logic got_manual, logic got_good, logic got_lost);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("result with no request pending (m=%b g=%b l=%b)",
                                 got_manual, got_good, got_lost));
                return;
            end
            want = expected_q.pop_front();
            if (got_manual !== want.manual_mode)
                report($sformatf("manual_mode %b, want %b", got_manual, want.manual_mode));
            if (got_good !== want.pulse_good)
                report($sformatf("pulse_good %b, want %b", got_good, want.pulse_good));
            if (got_lost !== want.signal_lost)
                report($sformatf("signal_lost %b, want %b", got_lost, want.signal_lost));
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rc_signal_presence_selector_core.
// ----------------------------------------------------------------------------
// Tick and pin-change requests go in through the valid/stall request channel;
// every request returns one result. A scoreboard tracks the pulse timers,
// the good-pulse count and the mode, and checks each result in order.
// A directed part walks window bounds, signal loss, zero tick step, the
// out-of-range pulse count and a lowered pulse count; then random pulse
// trains under several random register settings.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rcsps_pkg::*;
    import rcsps_tb_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int unsigned HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned CFG_EVERY    = 400;   // random requests per setting
    localparam int unsigned DRAIN_CYCLES = 8;     // two register stages, plus slack

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  operation;
    logic                  rx_level;
    logic                  out_valid;
    logic                  out_stall;
    logic                  manual_mode;
    logic                  pulse_good;
    logic                  signal_lost;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rc_mode_scoreboard mode_sb;
    int                tx_calm;
    int                rx_calm;
    bit                hold_req;      // ask the receiver for one long hold-off
    bit                result_taken;  // a result moved at the last rising edge
    int unsigned       quiet_cycles;

    rc_signal_presence_selector_core #(
        .TIME_WIDTH (TB_TIME_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .rx_level    (rx_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .manual_mode (manual_mode),
        .pulse_good  (pulse_good),
        .signal_lost (signal_lost),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length after a transfer: mostly none, some short, a few long.
    // Now and then a calm stretch with no gaps at all.
    function automatic int unsigned pick_gap(inout int calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 10);
        return $urandom_range(11, 40);
    endfunction

    // Offer one request from a falling edge, hold it until accepted, then
    // maybe idle. Valid is only lowered when a gap follows, so back-to-back
    // requests keep it high with a single assignment per step.
    task automatic send_request(input logic op, input logic level);
        int unsigned n;
        operation <= op;
        rx_level  <= level;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        mode_sb.note_request(op, level);
        @(negedge clk);
        n = pick_gap(tx_calm);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_ticks(input logic level, input int unsigned count);
        repeat (count) send_request(OP_TICK, level);
    endtask

    // rising edge, high ticks, falling edge, low ticks; the next rising
    // edge closes the pulse
    task automatic send_pulse(input int unsigned high_ticks, input int unsigned low_ticks);
        send_request(OP_EDGE, 1'b1);
        send_ticks(1'b1, high_ticks);
        send_request(OP_EDGE, 1'b0);
        send_ticks(1'b0, low_ticks);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (mode_sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        mode_sb.write_reg(idx, data);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Full register set, written only once the block is empty. The unused
    // index gets junk each time and must leave everything unchanged.
    task automatic program_all(input logic [CFG_DATA_W-1:0] step,
                               input logic [CFG_DATA_W-1:0] timeout,
                               input logic [CFG_DATA_W-1:0] needed,
                               input logic [CFG_DATA_W-1:0] pmin,
                               input logic [CFG_DATA_W-1:0] pmax,
                               input logic [CFG_DATA_W-1:0] wmin,
                               input logic [CFG_DATA_W-1:0] wmax);
        drain();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        write_reg(REG_TICK_STEP, step);
        write_reg(REG_LOSS_TIMEOUT, timeout);
        write_reg(REG_PULSES_NEEDED, needed);
        write_reg(REG_PERIOD_MIN, pmin);
        write_reg(REG_PERIOD_MAX, pmax);
        write_reg(REG_WIDTH_MIN, wmin);
        write_reg(REG_WIDTH_MAX, wmax);
    endtask

    // Receiver: stall decided at each falling edge, one assignment per step.
    // Gaps mostly follow a taken result, sometimes fall at random; one long
    // hold-off on request lets the pipeline fill and push back on the sender.
    initial
    begin
        int unsigned hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            else if (hold_left == 0 && rst_n &&
                     (result_taken || $urandom_range(0, 19) == 0))
                hold_left = pick_gap(rx_calm);
            result_taken = 1'b0;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result check and watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            mode_sb.check_result(manual_mode, pulse_good, signal_lost);
            result_taken = 1'b1;
        end
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int unsigned done_items;
        int unsigned next_cfg;
        int unsigned h;
        int unsigned l;
        int unsigned n;
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] wmin;
        logic [CFG_DATA_W-1:0] pmin;

        in_valid     = 1'b0;
        operation    = OP_TICK;
        rx_level     = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_TICK_STEP;
        cfg_data     = '0;
        rst_n        = 1'b0;
        tx_calm      = 0;
        rx_calm      = 0;
        hold_req     = 1'b0;
        result_taken = 1'b0;
        quiet_cycles = 0;
        mode_sb      = new();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: both tick levels, falling edge, an empty pulse
        send_request(OP_TICK, 1'b0);
        send_request(OP_TICK, 1'b1);
        send_request(OP_EDGE, 1'b0);
        send_request(OP_EDGE, 1'b1);

        // one-tick units: period window (2,8), width window (1,5),
        // loss beyond 3, manual after the first good pulse
        program_all(1, 3, 0, 2, 8, 1, 5);
        send_pulse(3, 2);        // closes nothing useful
        send_pulse(5, 2);        // closes 3/2: good, goes manual
        send_pulse(1, 5);        // width at upper bound; then loss drops manual
        send_pulse(2, 0);        // width at lower bound
        send_pulse(4, 4);        // period at lower bound; loss on 4th low tick
        send_pulse(2, 2);        // period at upper bound
        send_request(OP_EDGE, 1'b1); // 2/2 closes good
        send_ticks(1'b0, 3);     // low time 3, not beyond the timeout

        // zero tick step: timers hold but loss check still fires (3 > 0)
        program_all(0, 0, 15, 0, 24'hFF_FFFF, 0, 24'h00_FFFF);
        send_ticks(1'b0, 2);
        send_ticks(1'b1, 2);
        send_request(OP_EDGE, 1'b1);

        // pulse count out of range: count stops at 15, never manual
        program_all(1, 24'hFF_FFFF, 15, 0, 24'hFF_FFFF, 0, 24'h00_FFFF);
        repeat (17) send_pulse(1, 1);
        // lowered count: next good pulse clamps and goes manual
        program_all(1, 24'hFF_FFFF, 2, 0, 24'hFF_FFFF, 0, 24'h00_FFFF);
        send_pulse(1, 1);
        send_request(OP_EDGE, 1'b1);

        // random pulse trains, windows scaled by the tick step
        done_items = 0;
        next_cfg   = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            if (done_items >= next_cfg)
            begin
                step = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(9, 255))
                                                   : CFG_DATA_W'($urandom_range(1, 8));
                wmin = CFG_DATA_W'(step * $urandom_range(0, 3));
                pmin = CFG_DATA_W'(step * $urandom_range(2, 6));
                program_all(step,
                            CFG_DATA_W'(step * $urandom_range(4, 30)),
                            CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 14
                                                                    : $urandom_range(0, 5)),
                            pmin,
                            CFG_DATA_W'(pmin + step * $urandom_range(2, 12)),
                            wmin,
                            CFG_DATA_W'(wmin + step * $urandom_range(1, 6)));
                next_cfg = next_cfg + CFG_EVERY;
                // first setting: hold results back while requests keep coming
                if (done_items == 0)
                    hold_req = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                h = $urandom_range(0, 8);
                l = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(0, 12);
                send_pulse(h, l);
                done_items = done_items + h + l + 2;
            end
            else
            begin
                // noise: stray ticks and edges of either level
                n = $urandom_range(1, 4);
                repeat (n) send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                done_items = done_items + n;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mode_sb.errors == 0 && mode_sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
src/rcsps_pkg.sv
src/rcsps_cfg.sv
src/rcsps_qual.sv
src/rc_signal_presence_selector_core.sv
tb/rcsps_tb_pkg.sv
tb/tb_top.sv
